### hw/rtl/ets_pkg.sv
// Shared types, constants and microcode table for the epoch seconds to calendar converter.
`timescale 1ns / 1ps
`default_nettype none
package ets_pkg;

  // Supported input range is 0 .. 2^SECONDS_BITS - 1
  localparam int SECONDS_BITS = 34;

  localparam int EPOCH_W = 34;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int M100_W  = 7;
  localparam int M400_W  = 9;
  localparam int K_W     = 25;   // widest subtrahend: seconds in a leap year

  // Mask of input bits that lie above the supported range
  localparam logic [63:0]        LOW_MASK64 = (64'd1 << SECONDS_BITS) - 64'd1;
  localparam logic [EPOCH_W-1:0] HI_MASK    = ~LOW_MASK64[EPOCH_W-1:0];

  localparam logic [K_W-1:0] SECS_YEAR      = K_W'(365 * 86400);
  localparam logic [K_W-1:0] SECS_LEAP_YEAR = K_W'(366 * 86400);
  localparam logic [K_W-1:0] SECS_DAY       = K_W'(86400);
  localparam logic [K_W-1:0] SECS_HOUR      = K_W'(3600);
  localparam logic [K_W-1:0] SECS_MIN       = K_W'(60);

  localparam logic [YEAR_W-1:0] BASE_YEAR    = YEAR_W'(1970);
  localparam logic [M100_W-1:0] BASE_MOD100  = M100_W'(1970 % 100);
  localparam logic [M400_W-1:0] BASE_MOD400  = M400_W'(1970 % 400);
  localparam logic [M100_W-1:0] LAST_MOD100  = M100_W'(99);
  localparam logic [M400_W-1:0] LAST_MOD400  = M400_W'(399);
  localparam logic [MONTH_W-1:0] FIRST_MONTH = MONTH_W'(1);

  // Sequencer steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_EMIT
  } step_t;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_IN,        // input word offered
    COND_LT,        // accumulator below the selected unit
    COND_OUT_FREE   // output register can take a word
  } cond_t;

  // Which unit the accumulator is measured against
  typedef enum logic [2:0] {
    K_NONE,
    K_YEAR,
    K_MONTH,
    K_DAY,
    K_HOUR,
    K_MIN
  } ksel_t;

  typedef struct packed {
    cond_t cond;
    ksel_t ksel;
    logic  load;
    logic  emit;
    step_t jump;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  sub;
    logic  emit;
    ksel_t ksel;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic lt;
  } stat_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               oor;
  } res_t;

  // Microcode: on a true condition take the jump, otherwise hold the step
  // (and in a walk step, subtract one unit and count it).
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{cond: COND_LT, ksel: K_NONE, load: 1'b0, emit: 1'b0, jump: S_IDLE};
    case (s)
      S_IDLE: begin
        w.cond = COND_IN;
        w.load = 1'b1;
        w.jump = S_YEAR;
      end
      S_YEAR: begin
        w.ksel = K_YEAR;
        w.jump = S_MONTH;
      end
      S_MONTH: begin
        w.ksel = K_MONTH;
        w.jump = S_DAY;
      end
      S_DAY: begin
        w.ksel = K_DAY;
        w.jump = S_HOUR;
      end
      S_HOUR: begin
        w.ksel = K_HOUR;
        w.jump = S_MIN;
      end
      S_MIN: begin
        w.ksel = K_MIN;
        w.jump = S_EMIT;
      end
      S_EMIT: begin
        w.cond = COND_OUT_FREE;
        w.emit = 1'b1;
        w.jump = S_IDLE;
      end
      default: begin
        w.cond = COND_IN;
        w.jump = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // Seconds in month m (1..12)
  function automatic logic [K_W-1:0] month_secs(input logic [MONTH_W-1:0] m, input logic lp);
    logic [K_W-1:0] r;
    case (m)
      4'd2:                 r = lp ? K_W'(29 * 86400) : K_W'(28 * 86400);
      4'd4, 4'd6, 4'd9,
      4'd11:                r = K_W'(30 * 86400);
      default:              r = K_W'(31 * 86400);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/epoch_seconds_to_calendar.sv
// Top level: seconds-since-epoch to Gregorian date and time of day.
// The walk makes one subtraction per whole year past 1970, per whole month, per whole day,
//   per hour and per minute, so its run time grows with the date.
// Throughput: one word at a time; the next word is taken the cycle after the previous one
//   has moved to the output register.
// Reset (rst, synchronous): sequencer returns to idle, output register empties.
`timescale 1ns / 1ps
`default_nettype none
module epoch_seconds_to_calendar
  import ets_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [EPOCH_W-1:0] epoch_seconds,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [YEAR_W-1:0]       cal_year,
  output logic [MONTH_W-1:0]      cal_month,
  output logic [DAY_W-1:0]        cal_day,
  output logic [HOUR_W-1:0]       hour_of_day,
  output logic [MIN_W-1:0]        minute_of_hour,
  output logic [SEC_W-1:0]        second_of_minute,
  output logic                    out_of_range
);

  // The conversion is a walk of repeated subtraction on one 34-bit accumulator.
  // Each walk step of the microcode subtracts one unit (year, month, day, hour,
  // minute) per cycle while it fits and counts it; when it no longer fits the
  // sequencer jumps to the next unit. What is left after minutes is the second.
  // The year walk dominates the run time, one subtraction per year past 1970.

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  logic  out_free;

  // Output register is free when empty or being drained this cycle
  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = ~ctrl.in_ready;

  ets_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ets_dpath u_dpath (
    .clk           (clk),
    .ctrl          (ctrl),
    .epoch_seconds (epoch_seconds),
    .stat          (stat),
    .res           (res)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      cal_year         <= res.year;
      cal_month        <= res.month;
      cal_day          <= res.day;
      hour_of_day      <= res.hour;
      minute_of_hour   <= res.minute;
      second_of_minute <= res.second;
      out_of_range     <= res.oor;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ets_useq.sv
// Microcode sequencer: step register, control ROM and conditional jump.
`timescale 1ns / 1ps
`default_nettype none
module ets_useq
  import ets_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  step_t  step;
  step_t  step_next;
  ucode_t uw;
  logic   go;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uw = ucode_rom(step);
    case (uw.cond)
      COND_IN:       go = in_valid;
      COND_LT:       go = stat.lt;
      COND_OUT_FREE: go = out_free;
      default:       go = 1'b1;
    endcase
    step_next     = go ? uw.jump : step;
    ctrl.in_ready = (uw.cond == COND_IN);
    ctrl.load     = uw.load & go;
    ctrl.emit     = uw.emit & go;
    ctrl.sub      = (uw.ksel != K_NONE) & ~go;
    ctrl.ksel     = uw.ksel;
  end

endmodule
`default_nettype wire

### hw/rtl/ets_dpath.sv
// Datapath: seconds accumulator, unit subtractor and calendar counters.
`timescale 1ns / 1ps
`default_nettype none
module ets_dpath
  import ets_pkg::*;
(
  input  wire logic               clk,
  input  wire ctrl_t              ctrl,
  input  wire logic [EPOCH_W-1:0] epoch_seconds,
  output stat_t                   stat,
  output res_t                    res
);

  logic [EPOCH_W-1:0] acc;
  logic               oor;
  logic [YEAR_W-1:0]  year;
  logic [M100_W-1:0]  ymod100;
  logic [M400_W-1:0]  ymod400;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;

  logic               leap;
  logic               in_range;
  logic [K_W-1:0]     unit;
  logic [EPOCH_W:0]   diff;

  // Full Gregorian rule from the mod-4/100/400 counters
  assign leap = ((year[1:0] == 2'd0) && (ymod100 != '0)) || (ymod400 == '0);
  assign in_range = ((epoch_seconds & HI_MASK) == '0);

  always_comb begin
    case (ctrl.ksel)
      K_YEAR:  unit = leap ? SECS_LEAP_YEAR : SECS_YEAR;
      K_MONTH: unit = month_secs(month, leap);
      K_DAY:   unit = SECS_DAY;
      K_HOUR:  unit = SECS_HOUR;
      K_MIN:   unit = SECS_MIN;
      default: unit = '0;
    endcase
    diff    = {1'b0, acc} - {{(EPOCH_W + 1 - K_W){1'b0}}, unit};
    stat.lt = diff[EPOCH_W];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc     <= in_range ? epoch_seconds : '0;
      oor     <= ~in_range;
      year    <= BASE_YEAR;
      ymod100 <= BASE_MOD100;
      ymod400 <= BASE_MOD400;
      month   <= FIRST_MONTH;
      day     <= '0;
      hour    <= '0;
      minute  <= '0;
    end else if (ctrl.sub) begin
      acc <= diff[EPOCH_W-1:0];
      case (ctrl.ksel)
        K_YEAR: begin
          year    <= year + YEAR_W'(1);
          ymod100 <= (ymod100 == LAST_MOD100) ? '0 : ymod100 + M100_W'(1);
          ymod400 <= (ymod400 == LAST_MOD400) ? '0 : ymod400 + M400_W'(1);
        end
        K_MONTH: month  <= month + MONTH_W'(1);
        K_DAY:   day    <= day + DAY_W'(1);
        K_HOUR:  hour   <= hour + HOUR_W'(1);
        K_MIN:   minute <= minute + MIN_W'(1);
        default: begin
        end
      endcase
    end
  end

  // Out-of-range words carry only the flag
  always_comb begin
    res.oor    = oor;
    res.year   = oor ? '0 : year;
    res.month  = oor ? '0 : month;
    res.day    = oor ? '0 : day + DAY_W'(1);
    res.hour   = oor ? '0 : hour;
    res.minute = oor ? '0 : minute;
    res.second = oor ? '0 : acc[SEC_W-1:0];
  end

endmodule
`default_nettype wire

### hw/rtl/ets_checker.sv
// Port-level checker for the epoch seconds to calendar converter, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ets_checker
  import ets_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [EPOCH_W-1:0] epoch_seconds,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [YEAR_W-1:0]  cal_year,
  input wire logic [MONTH_W-1:0] cal_month,
  input wire logic [DAY_W-1:0]   cal_day,
  input wire logic [HOUR_W-1:0]  hour_of_day,
  input wire logic [MIN_W-1:0]   minute_of_hour,
  input wire logic [SEC_W-1:0]   second_of_minute,
  input wire logic               out_of_range
);

  // A stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // One word in flight: busy straight after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a conversion is running");

  // Valid calendar fields on an in-range word
  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |->
      cal_year >= BASE_YEAR && cal_month >= 4'd1 && cal_month <= 4'd12 &&
      cal_day >= 5'd1 && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 &&
      second_of_minute <= 6'd59)
    else $error("calendar field outside its range");

  // Out-of-range word carries zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |->
      cal_year == '0 && cal_month == '0 && cal_day == '0 && hour_of_day == '0 &&
      minute_of_hour == '0 && second_of_minute == '0)
    else $error("out-of-range word with non-zero fields");

endmodule

bind epoch_seconds_to_calendar ets_checker u_ets_checker (.*);
`default_nettype wire

### dv/tb_epoch_seconds_to_calendar.sv
// Self-checking testbench for the epoch seconds to calendar converter.
`timescale 1ns / 1ps
module tb_epoch_seconds_to_calendar;
  import ets_pkg::*;

  localparam int RANDOM_WORDS = 580;
  localparam int HOLD_AT      = 40;    // accepted words before the long output hold-off
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 700;   // beyond the worst-case conversion latency

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input has a known value from time zero
  logic               in_valid      = 1'b0;
  logic [EPOCH_W-1:0] epoch_seconds = '0;
  logic               out_stall     = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [YEAR_W-1:0]  cal_year;
  logic [MONTH_W-1:0] cal_month;
  logic [DAY_W-1:0]   cal_day;
  logic [HOUR_W-1:0]  hour_of_day;
  logic [MIN_W-1:0]   minute_of_hour;
  logic [SEC_W-1:0]   second_of_minute;
  logic               out_of_range;

  epoch_seconds_to_calendar uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .epoch_seconds    (epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cal_year         (cal_year),
    .cal_month        (cal_month),
    .cal_day          (cal_day),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .out_of_range     (out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timestamps still to offer, and dates owed by the block in arrival order
  logic [EPOCH_W-1:0] stamps_to_send[$];
  res_t               dates_owed[$];

  int unsigned n_stamps_total = 0;
  int unsigned n_accepted     = 0;
  int unsigned n_converted    = 0;
  int unsigned n_errors       = 0;
  int unsigned n_leap_days    = 0;
  int unsigned n_blocked      = 0;   // cycles the input was held off while offered
  int unsigned year_lo        = 4095;
  int unsigned year_hi        = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic, written independently of the block
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  // Seconds since the epoch for a given UTC date and time
  function automatic longint secs_of_date(input int unsigned y, input int unsigned m,
                                          input int unsigned d, input int unsigned hh,
                                          input int unsigned mi, input int unsigned ss);
    longint days;
    days = 0;
    for (int unsigned k = 1970; k < y; k++) days += days_in_year(k);
    for (int unsigned k = 1; k < m; k++) days += month_length(y, k);
    days += d - 1;
    return days * 86400 + hh * 3600 + mi * 60 + ss;
  endfunction

  // Expected calendar date for one timestamp: split off the day, then walk
  // whole years and whole months from 1970-01.
  function automatic res_t calendar_of(input logic [EPOCH_W-1:0] stamp);
    res_t             r;
    logic [63:0]      s64;
    longint unsigned  days;
    int unsigned      sod;
    int unsigned      yr;
    int unsigned      mo;
    r   = '0;
    s64 = 64'(stamp);
    if ((s64 >> SECONDS_BITS) != 0) begin
      r.oor = 1'b1;
      return r;
    end
    days = s64 / 86400;
    sod  = int'(s64 % 86400);
    yr   = 1970;
    while (days >= days_in_year(yr)) begin
      days -= days_in_year(yr);
      yr++;
    end
    mo = 1;
    while (days >= month_length(yr, mo)) begin
      days -= month_length(yr, mo);
      mo++;
    end
    if (yr > 4095) begin
      r.oor = 1'b1;
      return r;
    end
    r.year   = YEAR_W'(yr);
    r.month  = MONTH_W'(mo);
    r.day    = DAY_W'(days + 1);
    r.hour   = HOUR_W'(sod / 3600);
    r.minute = MIN_W'((sod / 60) % 60);
    r.second = SEC_W'(sod % 60);
    return r;
  endfunction

  // Idling schedule by progress: sender light / receiver heavy, then swapped,
  // then a clean stretch with no idling at all.
  function automatic int unsigned idle_pct(input bit sender);
    if (n_accepted < n_stamps_total / 3)     return sender ? 22 : 66;
    if (n_accepted < 2 * n_stamps_total / 3) return sender ? 66 : 22;
    return 0;
  endfunction

  task automatic flag_mismatch(input string what);
    n_errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [EPOCH_W-1:0] clamp_stamp(input longint t);
    if (t < 0) return '0;
    if (t > longint'({EPOCH_W{1'b1}})) return {EPOCH_W{1'b1}};
    return EPOCH_W'(t);
  endfunction

  task automatic queue_directed();
    // second, minute, hour and day roll-overs right at the epoch, and the first month roll-over
    stamps_to_send.push_back(34'd0);
    stamps_to_send.push_back(34'd1);
    stamps_to_send.push_back(34'd59);
    stamps_to_send.push_back(34'd60);
    stamps_to_send.push_back(34'd3599);
    stamps_to_send.push_back(34'd3600);
    stamps_to_send.push_back(34'd86399);
    stamps_to_send.push_back(34'd86400);
    stamps_to_send.push_back(clamp_stamp(secs_of_date(1970, 1, 31, 23, 59, 59)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(1970, 2, 1, 0, 0, 0)));
    // ordinary leap year
    stamps_to_send.push_back(clamp_stamp(secs_of_date(1972, 2, 29, 12, 30, 30)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(1972, 3, 1, 0, 0, 0)));
    // year boundary and a century that is a leap year
    stamps_to_send.push_back(clamp_stamp(secs_of_date(1999, 12, 31, 23, 59, 59)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(2000, 1, 1, 0, 0, 0)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(2000, 2, 29, 23, 59, 59)));
    // 2100 is not a leap year, so Feb 28 runs straight into Mar 1; 2400 is one
    stamps_to_send.push_back(clamp_stamp(secs_of_date(2100, 2, 28, 23, 59, 59)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(2100, 3, 1, 0, 0, 0)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(2400, 2, 29, 6, 7, 8)));
    stamps_to_send.push_back(clamp_stamp(secs_of_date(2400, 12, 31, 23, 59, 59)));
    // 32-bit wrap point, top of the field and alternating bit patterns
    stamps_to_send.push_back(34'h0_FFFF_FFFF);
    stamps_to_send.push_back(34'h1_0000_0000);
    stamps_to_send.push_back(34'h2_AAAA_AAAA);
    stamps_to_send.push_back(34'h1_5555_5555);
    stamps_to_send.push_back(34'h3_FFFF_FFFE);
    stamps_to_send.push_back(34'h3_FFFF_FFFF);
  endtask

  task automatic queue_random();
    int unsigned kind;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    longint      t;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // first few years: short walks, keeps the run quick
        stamps_to_send.push_back(EPOCH_W'($urandom_range(0, 4 * 366 * 86400)));
      end else if (kind <= 5) begin
        // within a couple of seconds of a day edge on the first or last day of a month, leap years favoured
        y = $urandom_range(0, 1) ? 4 * $urandom_range(493, 628) : $urandom_range(1970, 2513);
        m = $urandom_range(1, 12);
        d = $urandom_range(0, 1) ? 1 : month_length(y, m);
        t = secs_of_date(y, m, d, 0, 0, 0) + longint'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) t += 86400 - 2;
        stamps_to_send.push_back(clamp_stamp(t));
      end else if (kind <= 8) begin
        stamps_to_send.push_back({2'($urandom_range(0, 3)), 32'($urandom())});
      end else begin
        // last months of the range
        stamps_to_send.push_back(EPOCH_W'(34'h3_FFFF_FFFF - $urandom_range(0, 200 * 86400)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued timestamps; a held word never changes while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) n_blocked++;
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          dates_owed.push_back(calendar_of(epoch_seconds));
          n_accepted <= n_accepted + 1;
        end
        if (stamps_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_valid      <= 1'b1;
          epoch_seconds <= stamps_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the output side, once, so the block backs up its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each taken result with the oldest owed date
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_converted++;
        if (dates_owed.size() == 0) begin
          flag_mismatch($sformatf("result %0d-%0d-%0d with no timestamp outstanding",
                                  cal_year, cal_month, cal_day));
        end else begin
          want = dates_owed.pop_front();
          if (cal_year !== want.year)
            flag_mismatch($sformatf("year %0d, want %0d", cal_year, want.year));
          if (cal_month !== want.month)
            flag_mismatch($sformatf("month %0d, want %0d", cal_month, want.month));
          if (cal_day !== want.day)
            flag_mismatch($sformatf("day %0d, want %0d", cal_day, want.day));
          if (hour_of_day !== want.hour)
            flag_mismatch($sformatf("hour %0d, want %0d", hour_of_day, want.hour));
          if (minute_of_hour !== want.minute)
            flag_mismatch($sformatf("minute %0d, want %0d", minute_of_hour, want.minute));
          if (second_of_minute !== want.second)
            flag_mismatch($sformatf("second %0d, want %0d", second_of_minute, want.second));
          if (out_of_range !== want.oor)
            flag_mismatch($sformatf("out_of_range %0b, want %0b", out_of_range, want.oor));
          if (want.month == 2 && want.day == 29) n_leap_days++;
          if (want.year < year_lo) year_lo = want.year;
          if (want.year > year_hi) year_hi = want.year;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct(1'b0));
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing of the run
  // ---------------------------------------------------------------------------
  initial begin
    queue_directed();
    queue_random();
    n_stamps_total = stamps_to_send.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // everything offered and taken, and every owed date delivered
    while (stamps_to_send.size() != 0 || in_valid || dates_owed.size() != 0)
      @(posedge clk);
    // any stray word would show within one conversion time
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("converted %0d timestamps, years %0d..%0d, %0d landing on Feb 29",
             n_converted, year_lo, year_hi, n_leap_days);
    $display("input held off for %0d cycles while offered", n_blocked);
    if (n_errors == 0 && dates_owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Time limit on the whole run; reaching it is an error
  initial begin
    #25_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
